// ===== design/agl1_pkg.sv =====
`default_nettype none
package agl1_pkg;

  localparam int unsigned ELEMENTS_DEF = 4096;

  localparam int unsigned IDX_W  = 12;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned GS_W   = 48;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L1   = 2'd2;

  // update modes
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_L1     = 2'd1;
  localparam logic [1:0] MODE_L1_POS = 2'd2;

  localparam logic [1:0]  MODE_RESET = MODE_L1;
  localparam logic [15:0] RATE_RESET = 16'd3277;
  localparam logic [31:0] L1_RESET   = 32'd0;

  typedef struct packed {
    logic [IDX_W-1:0]         elem_index;
    logic signed [DATA_W-1:0] gradient;
    logic                     new_pass;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_index;
    logic signed [DATA_W-1:0] new_weight;
  } out_item_t;

endpackage
`default_nettype wire

// ===== design/agl1_ram.sv =====
`default_nettype none
module agl1_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/adagrad_l1_weight_update_unit.sv =====
`default_nettype none
// AdaGrad / L1 dual-averaging weight updater. After reset the unit sweeps its
// element stores to zero, one element a cycle, with busy high. Then each
// gradient is taken with start while busy is low; the unit stays busy through
// a 32-step square root of the square sum and a 32-step division, both run
// on one shared 65-bit subtractor, and takes no new item until it is through
// with the last one. The result shows on res_o for exactly one cycle with
// res_valid_o, in the first idle cycle, and cannot be held off, so the
// receiver must take it then. Configuration must be written through cfg_we_i
// only while busy is low; the unit itself does not enforce this.
module adagrad_l1_weight_update_unit #(
  parameter int unsigned ELEMENTS = agl1_pkg::ELEMENTS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire agl1_pkg::in_item_t                   in_i,
  output logic                                      res_valid_o,
  output agl1_pkg::out_item_t                       res_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [agl1_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [31:0]                          cfg_data_i
);

  localparam int unsigned AW  = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int unsigned SQW = agl1_pkg::SQ_W;
  localparam int unsigned GSW = agl1_pkg::GS_W;
  localparam int unsigned RW  = SQW + GSW + agl1_pkg::DATA_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_NUM  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_DIV0 = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [4:0]    cnt_q, cnt_d;

  logic [1:0]  mode_q;
  logic [15:0] rate_q;
  logic [31:0] l1_q;
  logic [31:0] pass_q;

  agl1_pkg::in_item_t item_q;
  logic               idx_ok_q;

  logic [SQW-1:0]        s_q;
  logic signed [GSW-1:0] gs_q;
  logic signed [31:0]    w_q;
  logic [63:0]           prod_q;
  logic [47:0]           diff_q;
  logic                  cond_q;
  logic [63:0]           v_q, res_q, bit_q;
  logic [31:0]           rem_q, lo_q, quo_q;
  logic                  big_q;

  logic                  valid_q;
  agl1_pkg::out_item_t   out_q;

  logic          accept;
  logic [RW-1:0] ram_rdata, ram_wdata;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [16:0]   idx_ext;

  logic [64:0] sub_a, sub_b, sub_diff;
  logic        sub_ge;

  logic [31:0]        gabs;
  logic [64:0]        s_sum;
  logic signed [48:0] gs_sum;
  logic [47:0]        gsabs;
  logic [31:0]        r_val;
  logic [32:0]        div_t;
  logic [31:0]        mag;
  logic signed [32:0] step;
  logic signed [33:0] nw;
  logic signed [31:0] w_new;
  logic               gs_pos;

  assign accept  = start && (state_q == S_IDLE);
  assign busy    = (state_q != S_IDLE);
  assign idx_ext = 17'(item_q.elem_index);
  assign gabs    = item_q.gradient[31] ? (32'd0 - 32'(item_q.gradient))
                                       : 32'(item_q.gradient);
  assign r_val   = res_q[31:0];
  assign div_t   = {rem_q, lo_q[31]};
  assign gs_pos  = !gs_q[GSW-1] && (gs_q != '0);

  // shared subtractor for root and division steps
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_q)
      S_SQRT: begin
        sub_a = {1'b0, v_q};
        sub_b = {1'b0, res_q + bit_q};
      end
      S_DIV0: begin
        sub_a = {33'd0, prod_q[63:32]};
        sub_b = {33'd0, r_val};
      end
      S_DIV: begin
        sub_a = {32'd0, div_t};
        sub_b = {33'd0, r_val};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end
  assign sub_diff = sub_a - sub_b;
  assign sub_ge   = !sub_diff[64];

  assign s_sum  = {1'b0, ram_rdata[RW-1 -: SQW]} + {1'b0, prod_q};
  assign gs_sum = 49'(gs_q) + 49'(item_q.gradient);
  assign gsabs  = gs_q[GSW-1] ? (48'd0 - 48'(gs_q)) : 48'(gs_q);

  // final weight
  always_comb begin
    mag   = big_q ? 32'hFFFF_FFFF : quo_q;
    step  = '0;
    nw    = '0;
    w_new = '0;
    if (idx_ok_q) begin
      if (mode_q == agl1_pkg::MODE_PLAIN) begin
        if (res_q == '0) begin
          w_new = w_q;
        end else begin
          if (item_q.gradient[31]) begin
            step = mag[31] ? -33'sh1_0000_0000 + 33'sh0_8000_0000
                           : -$signed({1'b0, mag});
          end else begin
            step = mag[31] ? 33'sh0_7FFF_FFFF : $signed({1'b0, mag});
          end
          nw = 34'(w_q) - 34'(step);
          if (nw > 34'sh0_7FFF_FFFF) begin
            w_new = 32'sh7FFF_FFFF;
          end else if (nw < -34'sh0_8000_0000) begin
            w_new = -32'sh8000_0000;
          end else begin
            w_new = nw[31:0];
          end
        end
      end else if (cond_q && (r_val != '0)) begin
        if (gs_pos) begin
          w_new = mag[31] ? -32'sh8000_0000 : -$signed(mag);
        end else begin
          w_new = mag[31] ? 32'sh7FFF_FFFF : $signed(mag);
        end
        if ((mode_q == agl1_pkg::MODE_L1_POS) && w_new[31]) begin
          w_new = '0;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_RD;
      S_CLR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(ELEMENTS - 1)) state_d = S_IDLE;
      end
      S_RD:   state_d = S_SQ;
      S_SQ:   state_d = S_ACC;
      S_ACC:  state_d = S_NUM;
      S_NUM:  state_d = S_MUL;
      S_MUL: begin
        state_d = S_SQRT;
        cnt_d   = '0;
      end
      S_SQRT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd31) state_d = S_DIV0;
      end
      S_DIV0: begin
        state_d = S_DIV;
        cnt_d   = '0;
      end
      S_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 5'd31) state_d = S_FIN;
      end
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      cnt_q   <= '0;
      mode_q  <= agl1_pkg::MODE_RESET;
      rate_q  <= agl1_pkg::RATE_RESET;
      l1_q    <= agl1_pkg::L1_RESET;
      pass_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      valid_q <= (state_q == S_FIN);
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          agl1_pkg::REG_MODE: mode_q <= cfg_data_i[1:0];
          agl1_pkg::REG_RATE: rate_q <= cfg_data_i[15:0];
          agl1_pkg::REG_L1:   l1_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && in_i.new_pass && (mode_q != agl1_pkg::MODE_PLAIN) &&
          (pass_q != 32'hFFFF_FFFF)) begin
        pass_q <= pass_q + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_q   <= in_i;
          idx_ok_q <= (17'(in_i.elem_index) < 17'(ELEMENTS));
        end
      end
      S_SQ: begin
        gs_q   <= ram_rdata[RW-SQW-1 -: GSW];
        w_q    <= ram_rdata[31:0];
        prod_q <= gabs * gabs;
      end
      S_ACC: begin
        s_q <= s_sum[64] ? '1 : s_sum[63:0];
        if (gs_sum > 49'sh0_7FFF_FFFF_FFFF) begin
          gs_q <= 48'sh7FFF_FFFF_FFFF;
        end else if (gs_sum < -49'sh0_8000_0000_0000) begin
          gs_q <= -48'sh8000_0000_0000;
        end else begin
          gs_q <= gs_sum[47:0];
        end
        prod_q <= pass_q * l1_q;
      end
      S_NUM: begin
        cond_q <= ({16'd0, gsabs} > prod_q);
        diff_q <= gsabs - prod_q[47:0];
      end
      S_MUL: begin
        if (mode_q == agl1_pkg::MODE_PLAIN) begin
          prod_q <= rate_q * {16'd0, gabs};
        end else begin
          prod_q <= rate_q * diff_q;
        end
        v_q   <= s_q;
        res_q <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end
      S_SQRT: begin
        if (sub_ge) begin
          v_q   <= sub_diff[63:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_DIV0: begin
        big_q <= sub_ge;
        rem_q <= prod_q[63:32];
        lo_q  <= prod_q[31:0];
        quo_q <= '0;
      end
      S_DIV: begin
        if (sub_ge) begin
          rem_q <= sub_diff[31:0];
        end else begin
          rem_q <= div_t[31:0];
        end
        lo_q  <= {lo_q[30:0], 1'b0};
        quo_q <= {quo_q[30:0], sub_ge};
      end
      S_FIN: begin
        out_q.out_index  <= item_q.elem_index;
        out_q.new_weight <= w_new;
      end
      default: ;
    endcase
  end

  assign ram_addr  = (state_q == S_CLR) ? clr_q : idx_ext[AW-1:0];
  assign ram_we    = (state_q == S_CLR) || ((state_q == S_FIN) && idx_ok_q);
  assign ram_wdata = (state_q == S_CLR) ? '0 : {s_q, gs_q, w_new};

  agl1_ram #(
    .WIDTH(RW),
    .DEPTH(ELEMENTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign res_valid_o = valid_q;
  assign res_o       = out_q;

endmodule
`default_nettype wire
